@@ sv/kwm_pkg.sv @@
package kwm_pkg;

    localparam int DATA_W    = 32;
    localparam int SRC_OUT_W = 4;
    localparam int CFG_W     = 5;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 3;

    localparam logic [CFG_W-1:0] NUM_LISTS_RST = 5'd16;

    // Register index, taken from paddr[2] (registers sit on 4-byte steps).
    localparam logic REG_NUM_LISTS = 1'b0;

    typedef struct packed {
        logic latch;
        logic push_start;
        logic up_rd;
        logic up_cmp;
        logic advance;
        logic emit_chk;
        logic pop_last;
        logic pop_hold;
        logic dn_l;
        logic dn_r;
        logic dn_cmp;
        logic dn_fin;
        logic emit;
    } t_kwm_cmd;

    typedef struct packed {
        logic has;
        logic full;
        logic i_zero;
        logic up_swap;
        logic more_heads;
        logic size_zero;
        logic l_valid;
        logic r_valid;
        logic best_child;
        logic out_free;
    } t_kwm_status;

endpackage

@@ sv/kwm_in_if.sv @@
interface kwm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [kwm_pkg::DATA_W-1:0]   value;
    logic                                has_value;

    modport source (output valid, output value, output has_value, input ready);
    modport sink   (input valid, input value, input has_value, output ready);
endinterface

@@ sv/kwm_out_if.sv @@
interface kwm_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [kwm_pkg::DATA_W-1:0]    out_value;
    logic        [kwm_pkg::SRC_OUT_W-1:0] source_list;
    logic                                 done_res;

    modport source (output valid, output out_value, output source_list, output done_res,
                    input ready);
    modport sink   (input valid, input out_value, input source_list, input done_res,
                    output ready);
endinterface

@@ sv/kwm_ram.sv @@
module kwm_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/kwm_ctrl.sv @@
module kwm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  kwm_pkg::t_kwm_status i_status,
    output kwm_pkg::t_kwm_cmd    o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_DECIDE   = 13'b0000000000010,
        S_UP_RD    = 13'b0000000000100,
        S_UP_CMP   = 13'b0000000001000,
        S_ADV      = 13'b0000000010000,
        S_EMIT_CHK = 13'b0000000100000,
        S_POP_LAST = 13'b0000001000000,
        S_POP_HOLD = 13'b0000010000000,
        S_DN_L     = 13'b0000100000000,
        S_DN_R     = 13'b0001000000000,
        S_DN_CMP   = 13'b0010000000000,
        S_DN_FIN   = 13'b0100000000000,
        S_EMIT     = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_status.has && !i_status.full) begin
                    o_cmd.push_start = 1'b1;
                    n_state          = S_UP_RD;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_UP_RD: begin
                o_cmd.up_rd = 1'b1;
                n_state     = i_status.i_zero ? S_ADV : S_UP_CMP;
            end
            S_UP_CMP: begin
                o_cmd.up_cmp = 1'b1;
                n_state      = i_status.up_swap ? S_UP_RD : S_ADV;
            end
            S_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = i_status.more_heads ? S_IDLE : S_EMIT_CHK;
            end
            S_EMIT_CHK: begin
                o_cmd.emit_chk = 1'b1;
                n_state        = i_status.size_zero ? S_EMIT : S_POP_LAST;
            end
            S_POP_LAST: begin
                o_cmd.pop_last = 1'b1;
                n_state        = S_POP_HOLD;
            end
            S_POP_HOLD: begin
                o_cmd.pop_hold = 1'b1;
                n_state        = S_DN_L;
            end
            S_DN_L: begin
                o_cmd.dn_l = 1'b1;
                n_state    = i_status.l_valid ? S_DN_R : S_EMIT;
            end
            S_DN_R: begin
                o_cmd.dn_r = 1'b1;
                n_state    = i_status.r_valid ? S_DN_CMP : S_DN_FIN;
            end
            S_DN_CMP: begin
                o_cmd.dn_cmp = 1'b1;
                n_state      = S_DN_FIN;
            end
            S_DN_FIN: begin
                o_cmd.dn_fin = 1'b1;
                n_state      = i_status.best_child ? S_DN_L : S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ sv/kwm_dpath.sv @@
module kwm_dpath #(
    parameter int MAX_LISTS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic signed [kwm_pkg::DATA_W-1:0]    i_value,
    input  logic                                 i_has_value,
    input  logic [kwm_pkg::CFG_W-1:0]            i_num_lists,
    input  kwm_pkg::t_kwm_cmd                    i_cmd,
    output kwm_pkg::t_kwm_status                 o_status,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [kwm_pkg::DATA_W-1:0]    o_out_value,
    output logic [kwm_pkg::SRC_OUT_W-1:0]        o_source_list,
    output logic                                 o_done_res
);

    localparam int LW = $clog2(MAX_LISTS);
    localparam int CW = $clog2(MAX_LISTS + 1);
    localparam int NW = (CW > kwm_pkg::CFG_W) ? CW : kwm_pkg::CFG_W;
    localparam int DW = kwm_pkg::DATA_W;
    localparam int EW = DW + LW;

    // Heap entries are {value, source list}.
    function automatic logic f_before(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic signed [DW-1:0] va;
        logic signed [DW-1:0] vb;
        va = signed'(a[EW-1 -: DW]);
        vb = signed'(b[EW-1 -: DW]);
        if (va != vb) begin
            return va < vb;
        end
        return a[LW-1:0] < b[LW-1:0];
    endfunction

    logic [CW-1:0]       r_size;
    logic [CW-1:0]       r_cnt;
    logic                r_loading;
    logic [LW-1:0]       r_pending;
    logic                r_has;
    logic [EW-1:0]       r_new;
    logic [LW-1:0]       r_idx;
    logic [EW-1:0]       r_best;
    logic [LW-1:0]       r_best_idx;
    logic                r_best_child;
    logic [DW-1:0]       r_res_value;
    logic [LW-1:0]       r_res_src;
    logic                r_res_done;
    logic                r_out_valid;
    logic [DW-1:0]       r_out_value;
    logic [kwm_pkg::SRC_OUT_W-1:0] r_out_src;
    logic                r_out_done;

    logic                w_we;
    logic [LW-1:0]       w_waddr;
    logic [EW-1:0]       w_wdata;
    logic [LW-1:0]       w_raddr;
    logic [EW-1:0]       w_rdata;

    logic [NW-1:0]       w_nl;
    logic [NW-1:0]       w_n;
    logic [LW-1:0]       w_parent;
    logic [LW+1:0]       w_l;
    logic [LW+1:0]       w_r;
    logic [LW+1:0]       w_sz;
    logic                w_up_swap;
    logic                w_lt_hole;
    logic                w_lt_best;

    kwm_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_LISTS)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Lists per job, held to 1 .. MAX_LISTS.
    always_comb begin
        w_nl = NW'(i_num_lists);
        if (w_nl == '0) begin
            w_n = NW'(1);
        end else if (w_nl > NW'(MAX_LISTS)) begin
            w_n = NW'(MAX_LISTS);
        end else begin
            w_n = w_nl;
        end
    end

    assign w_parent  = LW'((r_idx - LW'(1)) >> 1);
    assign w_l       = {1'b0, r_idx, 1'b1};
    assign w_r       = w_l + (LW+2)'(1);
    assign w_sz      = (LW+2)'(r_size);
    assign w_up_swap = f_before(r_new, w_rdata);
    assign w_lt_hole = f_before(w_rdata, r_new);
    assign w_lt_best = f_before(w_rdata, r_best);

    always_comb begin
        o_status            = '0;
        o_status.has        = r_has;
        o_status.full       = (r_size == CW'(MAX_LISTS));
        o_status.i_zero     = (r_idx == '0);
        o_status.up_swap    = w_up_swap;
        o_status.more_heads = r_loading && ((NW'(r_cnt) + NW'(1)) < w_n);
        o_status.size_zero  = (r_size == '0);
        o_status.l_valid    = (w_l < w_sz);
        o_status.r_valid    = (w_r < w_sz);
        o_status.best_child = r_best_child;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    // Heap port: sift-up and sift-down move a hole and write the held
    // entry only where it finally settles.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_new;
        w_raddr = '0;
        if (i_cmd.up_rd) begin
            if (r_idx == '0) begin
                w_we = 1'b1;
            end else begin
                w_raddr = w_parent;
            end
        end
        if (i_cmd.up_cmp) begin
            w_we = 1'b1;
            if (w_up_swap) begin
                w_wdata = w_rdata;
            end
        end
        if (i_cmd.pop_last) begin
            w_raddr = r_size[LW-1:0];
        end
        if (i_cmd.dn_l) begin
            if (w_l < w_sz) begin
                w_raddr = w_l[LW-1:0];
            end else begin
                w_we = 1'b1;
            end
        end
        if (i_cmd.dn_r) begin
            w_raddr = w_r[LW-1:0];
        end
        if (i_cmd.dn_fin) begin
            w_we = 1'b1;
            if (r_best_child) begin
                w_wdata = r_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size       <= '0;
            r_cnt        <= '0;
            r_loading    <= 1'b1;
            r_pending    <= '0;
            r_has        <= 1'b0;
            r_best_child <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.latch) begin
                r_has <= i_has_value;
            end
            if (i_cmd.push_start) begin
                r_size <= r_size + CW'(1);
            end
            if (i_cmd.advance && r_loading) begin
                if (o_status.more_heads) begin
                    r_cnt <= r_cnt + CW'(1);
                end else begin
                    r_cnt <= '0;
                end
            end
            if (i_cmd.emit_chk) begin
                if (r_size == '0) begin
                    r_loading <= 1'b1;
                    r_cnt     <= '0;
                end else begin
                    r_size <= r_size - CW'(1);
                end
            end
            if (i_cmd.pop_last) begin
                r_pending <= w_rdata[LW-1:0];
                r_loading <= 1'b0;
            end
            if (i_cmd.dn_r) begin
                r_best_child <= w_lt_hole;
            end
            if (i_cmd.dn_cmp && w_lt_best) begin
                r_best_child <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_new <= {i_value, (r_loading ? r_cnt[LW-1:0] : r_pending)};
        end
        if (i_cmd.push_start) begin
            r_idx <= r_size[LW-1:0];
        end
        if (i_cmd.up_cmp && w_up_swap) begin
            r_idx <= w_parent;
        end
        if (i_cmd.emit_chk && (r_size == '0)) begin
            r_res_value <= '0;
            r_res_src   <= '0;
            r_res_done  <= 1'b1;
        end
        if (i_cmd.pop_last) begin
            r_res_value <= w_rdata[EW-1 -: DW];
            r_res_src   <= w_rdata[LW-1:0];
            r_res_done  <= 1'b0;
        end
        if (i_cmd.pop_hold) begin
            r_new <= w_rdata;
            r_idx <= '0;
        end
        if (i_cmd.dn_r) begin
            r_best_idx <= w_l[LW-1:0];
            r_best     <= w_lt_hole ? w_rdata : r_new;
        end
        if (i_cmd.dn_cmp && w_lt_best) begin
            r_best_idx <= w_r[LW-1:0];
            r_best     <= w_rdata;
        end
        if (i_cmd.dn_fin && r_best_child) begin
            r_idx <= r_best_idx;
        end
        if (i_cmd.emit) begin
            r_out_value <= r_res_value;
            r_out_src   <= kwm_pkg::SRC_OUT_W'(r_res_src);
            r_out_done  <= r_res_done;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_value   = signed'(r_out_value);
    assign o_source_list = r_out_src;
    assign o_done_res    = r_out_done;

endmodule

@@ sv/k_way_merge_min_heap.sv @@
// K-way merge of ascending signed streams through a min-heap of list heads.
// Input channel i_in: one beat per step (value, has_value). A job starts with
// num_lists loading beats, one per list in index order, each giving that list's
// head or marking it empty. Every later beat is the next element of the list
// named by the previous output beat, or an exhausted mark.
// Output channel o_out: one beat per step after the last head (out_value,
// source_list, done_res); ties on value go to the lower list index. A beat
// with done_res set ends the job and the block returns to loading.
// num_lists is written over the APB port at address 0; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// One item at a time: each beat passes the idle, decide and advance states, and a
// push reads and compares the parent per level climbed. A beat with a result adds
// a check and an emit that waits for a free output register; a pop takes the root
// and the last entry, then per level of the sift-down reads the children,
// compares them and writes the hole, all set by the one read port of the heap RAM.
// Reset empties the heap, selects 16 lists and starts in the loading phase.
// A stalled receiver holds the output register; the next input beat is still
// taken and worked on, and its result waits until the register frees up.
module k_way_merge_min_heap #(
    parameter int MAX_LISTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    kwm_in_if.sink                        i_in,
    kwm_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kwm_pkg::PADDR_W-1:0]   paddr,
    input  logic [kwm_pkg::APB_W-1:0]     pwdata,
    output logic [kwm_pkg::APB_W-1:0]     prdata,
    output logic                          pready
);

    logic [kwm_pkg::CFG_W-1:0] r_num_lists;
    kwm_pkg::t_kwm_cmd         w_cmd;
    kwm_pkg::t_kwm_status      w_status;
    logic                      w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_lists <= kwm_pkg::NUM_LISTS_RST;
        end else if (psel && penable && pwrite && (paddr[2] == kwm_pkg::REG_NUM_LISTS)) begin
            r_num_lists <= pwdata[kwm_pkg::CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == kwm_pkg::REG_NUM_LISTS) ?
                    kwm_pkg::APB_W'(r_num_lists) : '0;

    kwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    kwm_dpath #(
        .MAX_LISTS (MAX_LISTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (i_in.value),
        .i_has_value   (i_in.has_value),
        .i_num_lists   (r_num_lists),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_out_value   (o_out.out_value),
        .o_source_list (o_out.source_list),
        .o_done_res    (o_out.done_res)
    );

    assign i_in.ready = w_in_ready;

    // At most one datapath action is issued per cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("more than one datapath command in a cycle");

    // An accepted beat is worked on before the next one is taken.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_in_ready) |=> !w_in_ready)
        else $error("input taken while an item is in flight");

    // A done beat carries no element.
    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.done_res) |->
        (o_out.out_value == 0) && (o_out.source_list == 0))
        else $error("done beat with nonzero payload");

    // A new output beat appears only after the controller emitted it.
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.emit))
        else $error("output valid without an emit");

endmodule
